/* src/e2d_pkg.sv */
// ----------------------------------------------------------------------------
// e2d_pkg
// Shared types, constants and calendar tables for the seconds-to-date
// converter.
// ----------------------------------------------------------------------------
package e2d_pkg;

    // Width of the seconds count that is converted
    localparam int SECONDS_WIDTH = 32;
    // Working width of the seconds remainder; must hold a leap year of seconds
    localparam int CALC_W        = (SECONDS_WIDTH > 25) ? SECONDS_WIDTH : 25;

    localparam int EPOCH_W = 12;
    localparam int YEAR_W  = 13;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int YMOD_W  = 12;

    localparam logic [CALC_W-1:0]  SECS_PER_DAY     = CALC_W'(86400);
    localparam logic [CALC_W-1:0]  SECS_COMMON_YEAR = CALC_W'(31536000);
    localparam logic [CALC_W-1:0]  SECS_LEAP_YEAR   = CALC_W'(31622400);
    localparam logic [YMOD_W-1:0]  QUAD_CENTURY     = YMOD_W'(400);
    localparam logic [YMOD_W-1:0]  QUAD_CENT_LAST   = YMOD_W'(399);
    localparam logic [YMOD_W-1:0]  CENTURY_1        = YMOD_W'(100);
    localparam logic [YMOD_W-1:0]  CENTURY_2        = YMOD_W'(200);
    localparam logic [YMOD_W-1:0]  CENTURY_3        = YMOD_W'(300);
    localparam logic [EPOCH_W-1:0] EPOCH_RESET      = EPOCH_W'(1970);

    localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
    localparam logic [DAY_W-1:0]   DAY_FIRST = DAY_W'(1);

    // Configuration register indexes
    localparam logic REG_EPOCH_YEAR = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_YEAR,
        ST_MONTH,
        ST_DAY,
        ST_DONE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic mod_step;
        logic year_step;
        logic month_step;
        logic day_step;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic ymod_ge;
        logic year_ge;
        logic month_ge;
        logic day_ge;
    } t_sts;

    // Seconds in a month; February depends on the leap flag
    function automatic logic [CALC_W-1:0] month_secs(input logic [MONTH_W-1:0] month,
                                                     input logic leap);
        logic [CALC_W-1:0] secs;
        case (month)
            4'd2:    secs = leap ? CALC_W'(29 * 86400) : CALC_W'(28 * 86400);
            4'd4,
            4'd6,
            4'd9,
            4'd11:   secs = CALC_W'(30 * 86400);
            default: secs = CALC_W'(31 * 86400);
        endcase
        return secs;
    endfunction

endpackage

/* src/epoch_seconds_to_date.sv */
// One conversion at a time, set by the single-step subtract loop in the datapath: a
// new start is accepted only while not busy. busy stays high until the result is out.
// The result is held on the ports for the one o_done cycle; the receiver cannot stall.
// Reset (synchronous, active low) returns the sequencer to idle and epoch_year to 1970.
// ----------------------------------------------------------------------------
// epoch_seconds_to_date
// Converts seconds since January 1 of a configured epoch year into a
// Gregorian year, month and day; holds the APB configuration register.
// ----------------------------------------------------------------------------
module epoch_seconds_to_date (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // command channel
    input  logic                            start,
    output logic                            busy,
    input  logic [31:0]                     i_elapsed_seconds,
    // result channel
    output logic                            o_done,
    output logic [e2d_pkg::YEAR_W-1:0]      o_date_year,
    output logic [e2d_pkg::MONTH_W-1:0]     o_date_month,
    output logic [e2d_pkg::DAY_W-1:0]       o_date_day,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import e2d_pkg::*;

    logic [EPOCH_W-1:0] r_epoch_year;
    t_cmd               cmd;
    t_sts               sts;
    logic               accept;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign accept = start && !busy;

    // Hold the epoch year register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch_year <= EPOCH_RESET;
        end else if (wr_en && paddr[2] == REG_EPOCH_YEAR) begin
            r_epoch_year <= pwdata[EPOCH_W-1:0];
        end
    end

    // Read back the register
    assign prdata = (paddr[2] == REG_EPOCH_YEAR) ? 32'(r_epoch_year) : '0;

    e2d_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    e2d_dp u_dp (
        .i_clk             (i_clk),
        .i_cmd             (cmd),
        .i_elapsed_seconds (i_elapsed_seconds),
        .i_epoch_year      (r_epoch_year),
        .o_sts             (sts),
        .o_date_year       (o_date_year),
        .o_date_month      (o_date_month),
        .o_date_day        (o_date_day)
    );

endmodule

/* src/e2d_ctrl.sv */
// ----------------------------------------------------------------------------
// e2d_ctrl
// Sequencer: reduces the epoch year modulo 400, then strips whole years,
// whole months and whole days from the seconds remainder, one per cycle.
// ----------------------------------------------------------------------------
module e2d_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  e2d_pkg::t_sts i_sts,
    output e2d_pkg::t_cmd o_cmd,
    output logic          o_busy,
    output logic          o_done
);
    import e2d_pkg::*;

    t_state r_state;
    t_state n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance sequence and issue commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MOD;
                end
            end
            ST_MOD: begin
                if (i_sts.ymod_ge) begin
                    o_cmd.mod_step = 1'b1;
                end else begin
                    n_state = ST_YEAR;
                end
            end
            ST_YEAR: begin
                if (i_sts.year_ge) begin
                    o_cmd.year_step = 1'b1;
                end else begin
                    n_state = ST_MONTH;
                end
            end
            ST_MONTH: begin
                if (i_sts.month_ge) begin
                    o_cmd.month_step = 1'b1;
                end else begin
                    n_state = ST_DAY;
                end
            end
            ST_DAY: begin
                if (i_sts.day_ge) begin
                    o_cmd.day_step = 1'b1;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = (r_state == ST_DONE);

endmodule

/* src/e2d_dp.sv */
// ----------------------------------------------------------------------------
// e2d_dp
// Datapath: seconds remainder, year with its position in the 400-year
// cycle, month and day counters.
// ----------------------------------------------------------------------------
module e2d_dp (
    input  logic                             i_clk,
    input  e2d_pkg::t_cmd                    i_cmd,
    input  logic [31:0]                      i_elapsed_seconds,
    input  logic [e2d_pkg::EPOCH_W-1:0]      i_epoch_year,
    output e2d_pkg::t_sts                    o_sts,
    output logic [e2d_pkg::YEAR_W-1:0]       o_date_year,
    output logic [e2d_pkg::MONTH_W-1:0]      o_date_month,
    output logic [e2d_pkg::DAY_W-1:0]        o_date_day
);
    import e2d_pkg::*;

    logic [CALC_W-1:0]  r_secs;
    logic [YEAR_W-1:0]  r_year;
    logic [YMOD_W-1:0]  r_ymod;
    logic [MONTH_W-1:0] r_month;
    logic [DAY_W-1:0]   r_day;

    logic               leap;
    logic [CALC_W-1:0]  ylen;
    logic [CALC_W-1:0]  mlen;
    logic [YMOD_W-1:0]  ymod_inc;

    // Leap rule on the year's position in the 400-year cycle
    assign leap = (r_ymod[1:0] == 2'b00 && r_ymod != CENTURY_1 && r_ymod != CENTURY_2 &&
                   r_ymod != CENTURY_3);
    assign ylen = leap ? SECS_LEAP_YEAR : SECS_COMMON_YEAR;
    assign mlen = month_secs(r_month, leap);
    assign ymod_inc = (r_ymod == QUAD_CENT_LAST) ? '0 : r_ymod + YMOD_W'(1);

    assign o_sts.ymod_ge  = (r_ymod >= QUAD_CENTURY);
    assign o_sts.year_ge  = (r_secs >= ylen);
    assign o_sts.month_ge = (r_secs >= mlen);
    assign o_sts.day_ge   = (r_secs >= SECS_PER_DAY);

    // Load the word, reduce the year position modulo 400, then strip years, months and days
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_secs  <= CALC_W'(SECONDS_WIDTH'(i_elapsed_seconds));
            r_year  <= YEAR_W'(i_epoch_year);
            r_ymod  <= YMOD_W'(i_epoch_year);
            r_month <= MONTH_JAN;
            r_day   <= DAY_FIRST;
        end else if (i_cmd.mod_step) begin
            r_ymod <= r_ymod - QUAD_CENTURY;
        end else if (i_cmd.year_step) begin
            r_secs <= r_secs - ylen;
            r_year <= r_year + YEAR_W'(1);
            r_ymod <= ymod_inc;
        end else if (i_cmd.month_step) begin
            r_secs <= r_secs - mlen;
            if (r_month == MONTH_DEC) begin
                r_month <= MONTH_JAN;
                r_year  <= r_year + YEAR_W'(1);
                r_ymod  <= ymod_inc;
            end else begin
                r_month <= r_month + MONTH_W'(1);
            end
        end else if (i_cmd.day_step) begin
            r_secs <= r_secs - SECS_PER_DAY;
            r_day  <= r_day + DAY_W'(1);
        end
    end

    assign o_date_year  = r_year;
    assign o_date_month = r_month;
    assign o_date_day   = r_day;

endmodule
